[hw/rtl/oaes_pkg.sv]
// shared types and constants of the oversampling averager and filter
`timescale 1ns / 1ps
`default_nettype none

package oaes_pkg;

    // fixed field widths
    localparam int CH_W       = 2;
    localparam int OS_W       = 4;
    localparam int ALPHA_W    = 16;
    localparam int GAIN_W     = 24;
    localparam int FILT_W     = 24;
    localparam int FRAC_W     = 8;
    localparam int MV_W       = 16;
    localparam int GAINS      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // serial multiplier: multiplier operand bits and product width
    localparam int MUL_N     = 16;
    localparam int PROD_W    = GAIN_W + MUL_N;
    localparam int BIT_CNT_W = $clog2(MUL_N);

    // register reset values
    localparam logic [OS_W-1:0]    OS_RESET    = 4'd4;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd2113536;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OVERSAMPLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN0      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN1      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN2      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN3      = 3'd5;

    // sequencer states
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_ACC  = 9'b000000010,
        S_MUL1 = 9'b000000100,
        S_RND  = 9'b000001000,
        S_DIFF = 9'b000010000,
        S_MUL2 = 9'b000100000,
        S_STEP = 9'b001000000,
        S_UPD  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/oaes_if.sv]
// stream and configuration channel interfaces of the averager and filter
`timescale 1ns / 1ps
`default_nettype none

// raw sample channel
interface oaes_in_if #(
    parameter int SAMPLE_BITS = 12
) ();
    logic                       valid;
    logic                       ready;
    logic [oaes_pkg::CH_W-1:0]  channel;
    logic [SAMPLE_BITS-1:0]     sample;

    modport source (output valid, channel, sample, input ready);
    modport sink   (input valid, channel, sample, output ready);
endinterface

// filtered result channel
interface oaes_out_if ();
    logic                       valid;
    logic                       ready;
    logic [oaes_pkg::CH_W-1:0]  out_channel;
    logic [oaes_pkg::MV_W-1:0]  filtered_mv;
    logic                       saturated;

    modport source (output valid, out_channel, filtered_mv, saturated, input ready);
    modport sink   (input valid, out_channel, filtered_mv, saturated, output ready);
endinterface

// register write channel
interface oaes_cfg_if ();
    logic                             valid;
    logic                             ready;
    logic [oaes_pkg::CFG_IDX_W-1:0]   index;
    logic [oaes_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/oversampled_adc_ema_scaler.sv]
// oversampling averager, millivolt scaler and moving-average filter, top level
// a sample that does not close its group goes through ACC before the next beat is taken
// a group-closing sample passes ACC, MUL1, RND, DIFF, MUL2, STEP, UPD, OUT (first group:
// RND to OUT); both multiplies are bit-serial, one multiplier bit a cycle, 16 each
// a waiting result sits in the output register while the next sample is taken
// synchronous reset restores register defaults, clears group sums and counts, unseeds filters
`timescale 1ns / 1ps
`default_nettype none

module oversampled_adc_ema_scaler #(
    parameter int CHANNELS            = 4,
    parameter int SAMPLE_BITS         = 12,
    parameter int MAX_OVERSAMPLE_LOG2 = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    oaes_in_if.sink          i_in,
    oaes_out_if.source       o_out,
    oaes_cfg_if.sink         i_cfg
);

    localparam int SUM_W = SAMPLE_BITS + MAX_OVERSAMPLE_LOG2;
    localparam int CNT_W = MAX_OVERSAMPLE_LOG2 + 1;
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SCL_W = oaes_pkg::PROD_W - oaes_pkg::FRAC_W;
    localparam logic [oaes_pkg::OS_W-1:0] MAX_LG = oaes_pkg::OS_W'(MAX_OVERSAMPLE_LOG2);

    // configuration registers
    logic [oaes_pkg::OS_W-1:0]    r_os;
    logic [oaes_pkg::ALPHA_W-1:0] r_alpha;
    logic [oaes_pkg::GAIN_W-1:0]  r_gain [oaes_pkg::GAINS];

    // per-channel state
    logic [SUM_W-1:0]             r_sum    [CHANNELS];
    logic [CNT_W-1:0]             r_cnt    [CHANNELS];
    logic [oaes_pkg::FILT_W-1:0]  r_filt   [CHANNELS];
    logic                         r_seeded [CHANNELS];

    // sequencer and datapath
    oaes_pkg::t_state             r_state, n_state;
    logic [oaes_pkg::CH_W-1:0]    r_ch;
    logic [SAMPLE_BITS-1:0]       r_smp;
    logic [oaes_pkg::GAIN_W-1:0]  r_hi;
    logic [oaes_pkg::MUL_N-1:0]   r_lo;
    logic [oaes_pkg::GAIN_W-1:0]  r_mcand;
    logic [oaes_pkg::BIT_CNT_W-1:0] r_bit;
    logic [oaes_pkg::FILT_W-1:0]  r_scaled;
    logic                         r_sat;
    logic                         r_neg;
    logic [oaes_pkg::FILT_W-1:0]  r_step;

    // output register
    logic                         r_o_valid;
    logic [oaes_pkg::CH_W-1:0]    r_o_ch;
    logic [oaes_pkg::MV_W-1:0]    r_o_mv;
    logic                         r_o_sat;

    logic                         w_in_beat;
    logic                         w_cfg_clr;
    logic [IDX_W-1:0]             w_idx;
    logic [oaes_pkg::OS_W-1:0]    w_lg;
    logic [SUM_W-1:0]             w_sum_new;
    logic [CNT_W-1:0]             w_cnt_new;
    logic                         w_done;
    logic [SAMPLE_BITS-1:0]       w_avg;
    logic [oaes_pkg::GAIN_W:0]    w_psum;
    logic [oaes_pkg::PROD_W-1:0]  w_prod;
    logic                         w_mul_last;
    logic [SCL_W-1:0]             w_scl_raw;
    logic                         w_sat;
    logic [oaes_pkg::FILT_W-1:0]  w_scaled;
    logic [oaes_pkg::FILT_W-1:0]  w_prev;
    logic                         w_ge;
    logic [oaes_pkg::FILT_W-1:0]  w_diff;
    logic                         w_out_free;

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == oaes_pkg::S_IDLE);
    assign w_in_beat   = i_in.valid && (r_state == oaes_pkg::S_IDLE);
    assign w_cfg_clr   = i_cfg.valid && (i_cfg.index == oaes_pkg::CFG_OVERSAMPLE);
    assign w_out_free  = !r_o_valid || o_out.ready;

    assign o_out.valid       = r_o_valid;
    assign o_out.out_channel = r_o_ch;
    assign o_out.filtered_mv = r_o_mv;
    assign o_out.saturated   = r_o_sat;

    // channel slot and effective group size
    assign w_idx = IDX_W'(r_ch);
    assign w_lg  = (r_os > MAX_LG) ? MAX_LG : r_os;

    // group accumulation
    assign w_sum_new = r_sum[w_idx] + SUM_W'(r_smp);
    assign w_cnt_new = r_cnt[w_idx] + CNT_W'(1);
    assign w_done    = w_cnt_new >= (CNT_W'(1) << w_lg);
    assign w_avg     = SAMPLE_BITS'(w_sum_new >> w_lg);

    // shift-add multiplier step, product in {hi, lo}
    assign w_psum     = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);
    assign w_prod     = {r_hi, r_lo};
    assign w_mul_last = (r_bit == oaes_pkg::BIT_CNT_W'(oaes_pkg::MUL_N - 1));

    // scaled value rounded to 8 fraction bits and clamped
    assign w_scl_raw = w_prod[oaes_pkg::PROD_W-1:oaes_pkg::FRAC_W]
                     + SCL_W'(w_prod[oaes_pkg::FRAC_W-1]);
    assign w_sat     = |w_scl_raw[SCL_W-1:oaes_pkg::FILT_W];
    assign w_scaled  = w_sat ? '1 : w_scl_raw[oaes_pkg::FILT_W-1:0];

    // distance between new value and filter
    assign w_prev = r_filt[w_idx];
    assign w_ge   = r_scaled >= w_prev;
    assign w_diff = w_ge ? (r_scaled - w_prev) : (w_prev - r_scaled);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_os    <= oaes_pkg::OS_RESET;
            r_alpha <= oaes_pkg::ALPHA_RESET;
            for (int k = 0; k < oaes_pkg::GAINS; k++) begin
                r_gain[k] <= oaes_pkg::GAIN_RESET;
            end
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                oaes_pkg::CFG_OVERSAMPLE: r_os    <= i_cfg.data[oaes_pkg::OS_W-1:0];
                oaes_pkg::CFG_ALPHA:      r_alpha <= i_cfg.data[oaes_pkg::ALPHA_W-1:0];
                oaes_pkg::CFG_GAIN0:      r_gain[0] <= i_cfg.data[oaes_pkg::GAIN_W-1:0];
                oaes_pkg::CFG_GAIN1:      r_gain[1] <= i_cfg.data[oaes_pkg::GAIN_W-1:0];
                oaes_pkg::CFG_GAIN2:      r_gain[2] <= i_cfg.data[oaes_pkg::GAIN_W-1:0];
                oaes_pkg::CFG_GAIN3:      r_gain[3] <= i_cfg.data[oaes_pkg::GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // group sums, counts and seeded flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_sum[k]    <= '0;
                r_cnt[k]    <= '0;
                r_seeded[k] <= 1'b0;
            end
        end else begin
            if (w_cfg_clr) begin
                for (int k = 0; k < CHANNELS; k++) begin
                    r_sum[k] <= '0;
                    r_cnt[k] <= '0;
                end
            end else if (r_state == oaes_pkg::S_ACC) begin
                r_sum[w_idx] <= w_done ? '0 : w_sum_new;
                r_cnt[w_idx] <= w_done ? '0 : w_cnt_new;
            end
            if (r_state == oaes_pkg::S_RND) begin
                r_seeded[w_idx] <= 1'b1;
            end
        end
    end

    // filter values, seeded on a channel's first group
    always_ff @(posedge i_clk) begin
        if (r_state == oaes_pkg::S_RND && !r_seeded[w_idx]) begin
            r_filt[w_idx] <= w_scaled;
        end else if (r_state == oaes_pkg::S_UPD) begin
            r_filt[w_idx] <= r_neg ? (w_prev - r_step) : (w_prev + r_step);
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            oaes_pkg::S_IDLE: begin
                r_ch  <= i_in.channel;
                r_smp <= i_in.sample[SAMPLE_BITS-1:0];
            end
            oaes_pkg::S_ACC: begin
                r_hi    <= '0;
                r_lo    <= oaes_pkg::MUL_N'(w_avg);
                r_mcand <= r_gain[r_ch];
                r_bit   <= '0;
            end
            oaes_pkg::S_MUL1, oaes_pkg::S_MUL2: begin
                r_hi  <= w_psum[oaes_pkg::GAIN_W:1];
                r_lo  <= {w_psum[0], r_lo[oaes_pkg::MUL_N-1:1]};
                r_bit <= r_bit + oaes_pkg::BIT_CNT_W'(1);
            end
            oaes_pkg::S_RND: begin
                r_scaled <= w_scaled;
                r_sat    <= w_sat;
            end
            oaes_pkg::S_DIFF: begin
                r_neg   <= !w_ge;
                r_hi    <= '0;
                r_lo    <= r_alpha;
                r_mcand <= w_diff;
                r_bit   <= '0;
            end
            oaes_pkg::S_STEP: begin
                // round half up on the 16 dropped fraction bits
                r_step <= w_prod[oaes_pkg::PROD_W-1:oaes_pkg::ALPHA_W]
                        + oaes_pkg::FILT_W'(w_prod[oaes_pkg::ALPHA_W-1]);
            end
            default: begin
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            oaes_pkg::S_IDLE: begin
                if (w_in_beat && (int'(i_in.channel) < CHANNELS)) begin
                    n_state = oaes_pkg::S_ACC;
                end
            end
            oaes_pkg::S_ACC: begin
                n_state = w_done ? oaes_pkg::S_MUL1 : oaes_pkg::S_IDLE;
            end
            oaes_pkg::S_MUL1: begin
                if (w_mul_last) begin
                    n_state = oaes_pkg::S_RND;
                end
            end
            oaes_pkg::S_RND: begin
                n_state = r_seeded[w_idx] ? oaes_pkg::S_DIFF : oaes_pkg::S_OUT;
            end
            oaes_pkg::S_DIFF: begin
                n_state = oaes_pkg::S_MUL2;
            end
            oaes_pkg::S_MUL2: begin
                if (w_mul_last) begin
                    n_state = oaes_pkg::S_STEP;
                end
            end
            oaes_pkg::S_STEP: begin
                n_state = oaes_pkg::S_UPD;
            end
            oaes_pkg::S_UPD: begin
                n_state = oaes_pkg::S_OUT;
            end
            oaes_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = oaes_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = oaes_pkg::S_IDLE;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oaes_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == oaes_pkg::S_OUT && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // output register payload, whole millivolts of the updated filter
    always_ff @(posedge i_clk) begin
        if (r_state == oaes_pkg::S_OUT && w_out_free) begin
            r_o_ch  <= r_ch;
            r_o_mv  <= w_prev[oaes_pkg::FILT_W-1:oaes_pkg::FRAC_W];
            r_o_sat <= r_sat;
        end
    end

endmodule

`default_nettype wire
